### hdl/wcva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed class vote package
// Shared field widths, the request record passed from the front end to the
// back end, and the back-end state encoding.
// ----------------------------------------------------------------------------
package wcva_pkg;

  // Fixed field widths of the request and result ports.
  localparam int unsigned CLS_W  = 4;
  localparam int unsigned CONF_W = 16;
  localparam int unsigned CFG_W  = 4;
  localparam int unsigned BEST_W = 3;

  // Active class count, 0 to 15 inclusive.
  localparam int unsigned NUM_W = 5;

  // Value of the class count register after reset.
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Decoupling queue between front and back end.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  // One classified request as seen by the back end.
  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [CONF_W-1:0] conf;
    logic              acc;
    logic [NUM_W-1:0]  num;
  } item_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN
  } state_e;

endpackage

### hdl/wcva_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered. A read and a write
// to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module wcva_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array, no reset.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/wcva_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed class vote front end
// Holds the class count register, classifies each incoming request as in use
// or rejected, and buffers it in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module wcva_front #(
  parameter int unsigned MAX_CLASSES = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         classes_in_use_we_i,
  input  logic [wcva_pkg::CFG_W-1:0]   classes_in_use_i,
  input  logic                         push_i,
  input  logic [wcva_pkg::CLS_W-1:0]   class_index_i,
  input  logic [wcva_pkg::CONF_W-1:0]  confidence_i,
  output logic                         full_o,
  output wcva_pkg::item_t              head_o,
  output logic                         head_valid_o,
  input  logic                         head_pop_i
);
  import wcva_pkg::*;

  logic [CFG_W-1:0]   cfg_q;
  logic [NUM_W-1:0]   num_act;
  item_t              item_in;
  item_t              mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] count_q, count_d;
  logic               do_push, do_pop;

  // Class count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (classes_in_use_we_i) begin
      cfg_q <= classes_in_use_i;
    end
  end

  // Active class count is clamped to the number of classes provided for.
  always_comb begin
    if (NUM_W'(cfg_q) > NUM_W'(MAX_CLASSES)) begin
      num_act = NUM_W'(MAX_CLASSES);
    end else begin
      num_act = NUM_W'(cfg_q);
    end
    item_in.cls  = class_index_i;
    item_in.conf = confidence_i;
    item_in.acc  = NUM_W'(class_index_i) < num_act;
    item_in.num  = num_act;
  end

  assign full_o       = (count_q == Q_CNT_W'(Q_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = head_pop_i && head_valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - Q_CNT_W'(1);
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
    end
  end

  // Queue entries carry payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  // The queue never holds more requests than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Q_CNT_W'(Q_DEPTH))
    else $error("front queue level beyond its depth");

  // A full queue always offers a request to the back end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> head_valid_o)
    else $error("front queue full but nothing at its head");

  // The request at the head stays put until the back end takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid_o && !head_pop_i) |=> (head_valid_o && $stable(head_o)))
    else $error("front queue head lost or changed");

endmodule

### hdl/wcva_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed class vote back end
// Pushes an accepted confidence into its class window in RAM, updates the
// running sum during a one-class-per-cycle argmax scan whose last class waits
// for a free output register, and holds the result there until it is taken.
// ----------------------------------------------------------------------------
module wcva_back #(
  parameter int unsigned WINDOW_DEPTH = 8,
  parameter int unsigned MAX_CLASSES  = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wcva_pkg::item_t              head_i,
  input  logic                         head_valid_i,
  output logic                         head_pop_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic                         accepted_o,
  output logic [wcva_pkg::BEST_W-1:0]  best_class_o,
  output logic                         best_valid_o
);
  import wcva_pkg::*;

  localparam int unsigned PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SLOT_W = $clog2(2 * WINDOW_DEPTH);
  localparam int unsigned IDX_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned DEPTH  = MAX_CLASSES * WINDOW_DEPTH;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SUM_W  = CONF_W + FILL_W;

  localparam logic [FILL_W-1:0] WD_F = FILL_W'(WINDOW_DEPTH);
  localparam logic [SLOT_W-1:0] WD_S = SLOT_W'(WINDOW_DEPTH);
  localparam logic [AW-1:0]     WD_A = AW'(WINDOW_DEPTH);

  // Per-class window bookkeeping.
  logic [FILL_W-1:0] fill_q   [MAX_CLASSES];
  logic [PTR_W-1:0]  oldest_q [MAX_CLASSES];
  logic [SUM_W-1:0]  sum_q    [MAX_CLASSES];

  state_e            state_q, state_d;
  item_t             cur_q;
  logic [IDX_W-1:0]  cls_q;
  logic              full_q;
  logic [PTR_W-1:0]  slot_q;
  logic [AW-1:0]     addr_q;
  logic [CONF_W-1:0] old_q;
  logic [IDX_W-1:0]  scan_q;
  logic [IDX_W-1:0]  best_q;
  logic [SUM_W-1:0]  best_sum_q;

  logic              out_valid_q;
  logic              acc_out_q;
  logic [BEST_W-1:0] best_class_q;
  logic              best_valid_q;

  logic [IDX_W-1:0]  cls_h;
  logic              full_h;
  logic [SLOT_W-1:0] wrap_h;
  logic [PTR_W-1:0]  slot_h;
  logic [AW-1:0]     addr_h;
  logic [CONF_W-1:0] rdata;

  logic              in_range, hit, take, last, out_free;
  logic [SUM_W-1:0]  cand;
  logic [SUM_W-1:0]  best_sum_n;
  logic [IDX_W-1:0]  best_n;

  logic              ld, upd, step, out_wr;

  // Slot and address of the request at the queue head.
  always_comb begin
    cls_h  = head_i.cls[IDX_W-1:0];
    full_h = fill_q[cls_h] >= WD_F;
    wrap_h = SLOT_W'(oldest_q[cls_h]) + SLOT_W'(fill_q[cls_h]);
    if (wrap_h >= WD_S) begin
      wrap_h = wrap_h - WD_S;
    end
    slot_h = full_h ? oldest_q[cls_h] : PTR_W'(wrap_h);
    addr_h = AW'(cls_h) * WD_A + AW'(slot_h);
  end

  // Window store: read the evicted value, then write the new one.
  wcva_ram #(
    .WIDTH (CONF_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (upd),
    .waddr_i (addr_q),
    .wdata_i (cur_q.conf),
    .re_i    (ld && head_i.acc),
    .raddr_i (addr_h),
    .rdata_o (rdata)
  );

  // One scan step: the updated class picks up its new sum on the way past.
  always_comb begin
    in_range = NUM_W'(scan_q) < cur_q.num;
    hit      = cur_q.acc && (scan_q == cls_q);
    if (hit) begin
      cand = sum_q[scan_q] + SUM_W'(cur_q.conf) - SUM_W'(old_q);
    end else begin
      cand = sum_q[scan_q];
    end
    take       = in_range && (cand > best_sum_q);
    best_sum_n = take ? cand : best_sum_q;
    best_n     = take ? scan_q : best_q;
    last       = (NUM_W'(scan_q) + NUM_W'(1)) >= cur_q.num;
    out_free   = !out_valid_q || pop_i;
  end

  // Sequencer next state and controls.
  always_comb begin
    state_d    = state_q;
    head_pop_o = 1'b0;
    ld         = 1'b0;
    upd        = 1'b0;
    step       = 1'b0;
    out_wr     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          head_pop_o = 1'b1;
          ld         = 1'b1;
          state_d    = head_i.acc ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_UPDATE: begin
        upd     = 1'b1;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!last) begin
          step = 1'b1;
        end else if (out_free) begin
          step    = 1'b1;
          out_wr  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers of the request in flight.
  always_ff @(posedge clk_i) begin
    if (ld) begin
      cur_q      <= head_i;
      cls_q      <= cls_h;
      full_q     <= full_h;
      slot_q     <= slot_h;
      addr_q     <= addr_h;
      scan_q     <= '0;
      best_q     <= '0;
      best_sum_q <= '0;
    end else if (step) begin
      scan_q     <= scan_q + IDX_W'(1);
      best_q     <= best_n;
      best_sum_q <= best_sum_n;
    end
    if (upd) begin
      old_q <= full_q ? rdata : '0;
    end
  end

  // Per-class fill level, oldest slot and running sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CLASSES; i++) begin
        fill_q[i]   <= '0;
        oldest_q[i] <= '0;
        sum_q[i]    <= '0;
      end
    end else begin
      if (upd) begin
        if (full_q) begin
          oldest_q[cls_q] <= (SLOT_W'(slot_q) + SLOT_W'(1) == WD_S) ? '0
                                                                  : slot_q + PTR_W'(1);
        end else begin
          fill_q[cls_q] <= fill_q[cls_q] + FILL_W'(1);
        end
      end
      if (step && hit) begin
        sum_q[scan_q] <= cand;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_wr) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (out_wr) begin
      acc_out_q    <= cur_q.acc;
      best_class_q <= BEST_W'(best_n);
      best_valid_q <= (best_sum_n != '0);
    end
  end

  assign empty_o      = !out_valid_q;
  assign accepted_o   = acc_out_q;
  assign best_class_o = best_class_q;
  assign best_valid_o = best_valid_q;

  // Only accepted requests touch the window store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |-> cur_q.acc)
    else $error("window update for a rejected request");

  // A waiting result is never dropped before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> (out_valid_q && $stable(best_class_q)))
    else $error("waiting result lost or changed");

  // The scan runs on until its last class.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && !last) |=> (state_q == ST_SCAN))
    else $error("scan left before the last class");

endmodule

### hdl/windowed_class_vote_argmax.sv
`timescale 1ns / 1ps
// Flow: a pushed request is registered in the front-end queue. The back end
//   takes it from the queue head, updates its class window (accepted requests
//   only), then runs the argmax scan one class per cycle over the N active
//   classes (N the active class count); the last waits for a free result
//   register. The back end finishes one request before it takes the next.
// Reset clears counts, sums, queue and result; the class count returns to 8.
// ----------------------------------------------------------------------------
// Windowed class vote argmax
// Per-class sliding window sums of confidence values with an argmax over the
// active classes, one result per request.
// ----------------------------------------------------------------------------
module windowed_class_vote_argmax #(
  parameter int unsigned WINDOW_DEPTH = 8,
  parameter int unsigned MAX_CLASSES  = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         classes_in_use_we_i,
  input  logic [wcva_pkg::CFG_W-1:0]   classes_in_use_i,
  input  logic                         push,
  output logic                         full,
  input  logic [wcva_pkg::CLS_W-1:0]   class_index_i,
  input  logic [wcva_pkg::CONF_W-1:0]  confidence_i,
  output logic                         empty,
  input  logic                         pop,
  output logic                         accepted_o,
  output logic [wcva_pkg::BEST_W-1:0]  best_class_o,
  output logic                         best_valid_o
);
  import wcva_pkg::*;

  item_t head;
  logic  head_valid;
  logic  head_pop;

  // Front end: class count register, classification and request queue.
  wcva_front #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .classes_in_use_we_i (classes_in_use_we_i),
    .classes_in_use_i    (classes_in_use_i),
    .push_i              (push),
    .class_index_i       (class_index_i),
    .confidence_i        (confidence_i),
    .full_o              (full),
    .head_o              (head),
    .head_valid_o        (head_valid),
    .head_pop_i          (head_pop)
  );

  // Back end: window update, argmax scan and result register.
  wcva_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MAX_CLASSES  (MAX_CLASSES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .accepted_o   (accepted_o),
    .best_class_o (best_class_o),
    .best_valid_o (best_valid_o)
  );

endmodule
